// File: hw/rtl/tad_pkg.sv
`timescale 1ns / 1ps

package tad_pkg;

    // Default side width, unsigned Q8.8.
    localparam int TAD_SIDE_BITS = 16;

    // Register stages in front of the root search of one lane.
    localparam int TAD_PRE_STAGES = 4;

endpackage

// File: hw/rtl/tad_side_if.sv
`timescale 1ns / 1ps

// Channel that carries the three sides of one triangle.
interface tad_side_if #(
    parameter int SIDE_BITS = tad_pkg::TAD_SIDE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [SIDE_BITS-1:0] side_a;
    logic [SIDE_BITS-1:0] side_b;
    logic [SIDE_BITS-1:0] side_c;

    modport source (output valid, output side_a, output side_b, output side_c, input ready);
    modport sink   (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

// File: hw/rtl/tad_result_if.sv
`timescale 1ns / 1ps

// Channel that carries the flag and the three bisector lengths.
interface tad_result_if #(
    parameter int SIDE_BITS = tad_pkg::TAD_SIDE_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 not_triangle;
    logic [SIDE_BITS-1:0] bisector_a;
    logic [SIDE_BITS-1:0] bisector_b;
    logic [SIDE_BITS-1:0] bisector_c;

    modport source (output valid, output not_triangle, output bisector_a,
                    output bisector_b, output bisector_c, input ready);
    modport sink   (input valid, input not_triangle, input bisector_a,
                    input bisector_b, input bisector_c, output ready);
endinterface

// File: hw/rtl/tad_ctrl.sv
`timescale 1ns / 1ps

// Valid chain of the pipeline. A stage loads when it is empty or when the
// stage after it moves on, so bubbles are squeezed out under a stall.
module tad_ctrl #(
    parameter int DEPTH = tad_pkg::TAD_SIDE_BITS + tad_pkg::TAD_PRE_STAGES + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_ready,
    output logic [DEPTH-1:0] o_move,
    output logic             o_valid_last
);
    logic [DEPTH-1:0] r_v;

    // Load enables ripple back from the output.
    always_comb begin
        o_move[DEPTH-1] = !r_v[DEPTH-1] || i_out_ready;
        for (int j = DEPTH - 2; j >= 0; j--) begin
            o_move[j] = !r_v[j] || o_move[j+1];
        end
    end

    // Occupancy of each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (o_move[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < DEPTH; j++) begin
                if (o_move[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    assign o_valid_last = r_v[DEPTH-1];
endmodule

// File: hw/rtl/tad_lane.sv
`timescale 1ns / 1ps

// One bisector: floor(sqrt(y*z*(s-x)*(s+x)) / s) with s = y+z, found one
// quotient bit per stage without a divider. The search keeps the remainder
// rem = R - q^2*s^2 and u = q*s^2, so each trial is an add and a compare.
module tad_lane #(
    parameter int SIDE_BITS = tad_pkg::TAD_SIDE_BITS
) (
    input  logic                 i_clk,
    input  logic [SIDE_BITS+tad_pkg::TAD_PRE_STAGES-1:0] i_en,
    input  logic [SIDE_BITS-1:0] i_x,
    input  logic [SIDE_BITS-1:0] i_y,
    input  logic [SIDE_BITS-1:0] i_z,
    output logic [SIDE_BITS-1:0] o_q
);
    import tad_pkg::*;

    localparam int SB  = SIDE_BITS;
    localparam int W   = 4 * SB + 4;
    localparam int UW  = 3 * SB + 2;
    localparam int S2W = 2 * SB + 2;
    localparam int DW  = 2 * SB + 3;
    localparam int BW  = 2 * SB;
    localparam int PW  = 3 * SB + 3;

    logic [SB-1:0]  r_x, r_y, r_z;
    logic [SB:0]    s, smx;
    logic [SB+1:0]  spx;
    logic [BW-1:0]  r_bc;
    logic [DW-1:0]  r_dd;
    logic [S2W-1:0] r_s2_a, r_s2_b;
    logic [PW-1:0]  r_plo, r_phi;
    logic [W-1:0]   r_rem [SB];
    logic [UW-1:0]  r_u   [SB];
    logic [S2W-1:0] r_s2  [SB];
    logic [SB-1:0]  r_q   [SB+1];

    // Capture the sides.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end
    end

    assign s   = {1'b0, r_y} + {1'b0, r_z};
    assign smx = s - {1'b0, r_x};
    assign spx = {1'b0, s} + {2'b00, r_x};

    // Three independent products of the sides.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_bc   <= BW'(r_y) * BW'(r_z);
            r_dd   <= DW'(smx) * DW'(spx);
            r_s2_a <= S2W'(s) * S2W'(s);
        end
    end

    // The wide radicand as two partial products.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_plo  <= PW'(r_bc[SB-1:0]) * PW'(r_dd);
            r_phi  <= PW'(r_bc[BW-1:SB]) * PW'(r_dd);
            r_s2_b <= r_s2_a;
        end
    end

    // Sum the partial products and start the search.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_rem[0] <= W'(r_plo) + (W'(r_phi) << SB);
            r_u[0]   <= '0;
            r_s2[0]  <= r_s2_b;
            r_q[0]   <= '0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < SB; i++) begin : g_bit
        localparam int K = SB - 1 - i;
        logic [W-1:0] d;
        logic         take;

        // (q + 2^K)^2 s^2 - q^2 s^2 = (u << (K+1)) + (s^2 << 2K)
        assign d    = (W'(r_u[i]) << (K + 1)) + (W'(r_s2[i]) << (2 * K));
        assign take = d <= r_rem[i];

        always_ff @(posedge i_clk) begin
            if (i_en[TAD_PRE_STAGES+i]) begin
                r_q[i+1] <= take ? (r_q[i] | (SB'(1) << K)) : r_q[i];
            end
        end

        if (i < SB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[TAD_PRE_STAGES+i]) begin
                    r_rem[i+1] <= take ? r_rem[i] - d : r_rem[i];
                    r_u[i+1]   <= take ? r_u[i] + (UW'(r_s2[i]) << K) : r_u[i];
                    r_s2[i+1]  <= r_s2[i];
                end
            end
        end
    end

    assign o_q = r_q[SB];
endmodule

// File: hw/rtl/triangle_angle_bisectors.sv
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// i_side    in         side_a, side_b, side_c (unsigned fixed point)
// o_res     out        not_triangle, bisector_a, bisector_b, bisector_c
//
// One triangle is taken every cycle while o_res is not stalled; the pipeline is
// four set-up stages, one root-search stage per result bit and the output
// register. Three lanes run side by side, one for each bisector.
// Reset (synchronous, active low) empties the pipeline.
// A stall on o_res fills bubbles first, then holds i_side.ready low.
module triangle_angle_bisectors #(
    parameter int SIDE_BITS = tad_pkg::TAD_SIDE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tad_side_if.sink     i_side,
    tad_result_if.source o_res
);
    import tad_pkg::*;

    localparam int NST = SIDE_BITS + TAD_PRE_STAGES;

    logic [NST:0]         move;
    logic                 valid_last;
    logic                 bad;
    logic [NST-1:0]       r_bad;
    logic [SIDE_BITS-1:0] q_a, q_b, q_c;

    tad_ctrl #(.DEPTH(NST + 1)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_side.valid),
        .i_out_ready (o_res.ready),
        .o_move      (move),
        .o_valid_last(valid_last)
    );

    assign i_side.ready = move[0];

    // Zero sides and the strict triangle inequality.
    assign bad = (i_side.side_a == '0) || (i_side.side_b == '0) || (i_side.side_c == '0)
              || ({1'b0, i_side.side_a} + {1'b0, i_side.side_b} <= {1'b0, i_side.side_c})
              || ({1'b0, i_side.side_b} + {1'b0, i_side.side_c} <= {1'b0, i_side.side_a})
              || ({1'b0, i_side.side_c} + {1'b0, i_side.side_a} <= {1'b0, i_side.side_b});

    // The flag travels beside the lanes.
    always_ff @(posedge i_clk) begin
        if (move[0]) begin
            r_bad[0] <= bad;
        end
        for (int j = 1; j < NST; j++) begin
            if (move[j]) begin
                r_bad[j] <= r_bad[j-1];
            end
        end
    end

    tad_lane #(.SIDE_BITS(SIDE_BITS)) u_lane_a (
        .i_clk(i_clk), .i_en(move[NST-1:0]),
        .i_x(i_side.side_a), .i_y(i_side.side_b), .i_z(i_side.side_c), .o_q(q_a)
    );

    tad_lane #(.SIDE_BITS(SIDE_BITS)) u_lane_b (
        .i_clk(i_clk), .i_en(move[NST-1:0]),
        .i_x(i_side.side_b), .i_y(i_side.side_c), .i_z(i_side.side_a), .o_q(q_b)
    );

    tad_lane #(.SIDE_BITS(SIDE_BITS)) u_lane_c (
        .i_clk(i_clk), .i_en(move[NST-1:0]),
        .i_x(i_side.side_c), .i_y(i_side.side_a), .i_z(i_side.side_b), .o_q(q_c)
    );

    // Merge the lanes into the output register.
    always_ff @(posedge i_clk) begin
        if (move[NST]) begin
            o_res.not_triangle <= r_bad[NST-1];
            o_res.bisector_a   <= r_bad[NST-1] ? '0 : q_a;
            o_res.bisector_b   <= r_bad[NST-1] ? '0 : q_b;
            o_res.bisector_c   <= r_bad[NST-1] ? '0 : q_c;
        end
    end

    assign o_res.valid = valid_last;

    // An invalid triangle carries zero lengths.
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.not_triangle |->
            (o_res.bisector_a == '0) && (o_res.bisector_b == '0) && (o_res.bisector_c == '0))
        else $error("invalid triangle with nonzero bisector");

    // An empty output register leaves the whole pipeline free to move.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_side.ready)
        else $error("input stalled with empty output");

    // A taken result lets the input advance in the same cycle.
    a_taken_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ready |-> i_side.ready)
        else $error("input stalled while output is taken");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tad_pkg::*;

    localparam int SB = TAD_SIDE_BITS;
    localparam int LATENCY = SB + 5;
    localparam int RANDOM_COUNT = 1350;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic [SB-1:0] t_side;

    typedef struct packed {
        logic  not_triangle;
        t_side bisector_a;
        t_side bisector_b;
        t_side bisector_c;
    } t_bisectors;

    // One row of the directed table; check_value says whether the typed result is used.
    typedef struct {
        t_side      a;
        t_side      b;
        t_side      c;
        bit         check_value;
        t_bisectors value;
    } t_triangle_row;

    logic i_clk;
    logic i_rst_n;
    longint cycle_count;
    int     fail_count;
    bit     stim_done;
    t_bisectors pending_bisectors[$];

    tad_side_if   #(.SIDE_BITS(SB)) side_ch ();
    tad_result_if #(.SIDE_BITS(SB)) res_ch ();

    triangle_angle_bisectors #(.SIDE_BITS(SB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (side_ch.sink),
        .o_res   (res_ch.source)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact floor(sqrt(y*z*(s-x)*(s+x)) / s) with s = y + z, by bitwise search.
    function automatic t_side bisector_length(t_side x, t_side y, t_side z);
        logic [127:0] s;
        logic [127:0] target;
        logic [127:0] trial;
        logic [127:0] q;
        s = {112'd0, y} + {112'd0, z};
        target = {112'd0, y} * {112'd0, z} * (s - {112'd0, x}) * (s + {112'd0, x});
        q = '0;
        for (int bit_idx = SB - 1; bit_idx >= 0; bit_idx--) begin
            trial = q | (128'd1 << bit_idx);
            if (trial * trial * s * s <= target) begin
                q = trial;
            end
        end
        return q[SB-1:0];
    endfunction

    function automatic t_bisectors predict_bisectors(t_side a, t_side b, t_side c);
        t_bisectors r;
        logic [SB:0] sa;
        logic [SB:0] sb;
        logic [SB:0] sc;
        sa = {1'b0, a};
        sb = {1'b0, b};
        sc = {1'b0, c};
        r = '0;
        if (a == 0 || b == 0 || c == 0 || sa + sb <= sc || sb + sc <= sa || sc + sa <= sb) begin
            r.not_triangle = 1'b1;
        end else begin
            r.bisector_a = bisector_length(a, b, c);
            r.bisector_b = bisector_length(b, c, a);
            r.bisector_c = bisector_length(c, a, b);
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Valid stays high between transactions that follow with no gap.
    task automatic send_triangle(t_side a, t_side b, t_side c, bit use_gap);
        int gap;
        gap = use_gap ? pick_gap() : 0;
        if (gap > 0) begin
            side_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        side_ch.valid  <= 1'b1;
        side_ch.side_a <= a;
        side_ch.side_b <= b;
        side_ch.side_c <= c;
        pending_bisectors.push_back(predict_bisectors(a, b, c));
        do @(posedge i_clk); while (!side_ch.ready);
        @(negedge i_clk);
    endtask

    // A valid triangle with random content; mostly small sides, some full range.
    task automatic random_triangle(output t_side a, output t_side b, output t_side c);
        int hi;
        int lo;
        hi = ($urandom_range(0, 9) < 7) ? 255 : 65535;
        do begin
            a = t_side'($urandom_range(1, hi));
            b = t_side'($urandom_range(1, hi));
            lo = (a > b) ? a - b + 1 : b - a + 1;
            c = t_side'($urandom_range(lo, (a + b - 1 > 65535) ? 65535 : a + b - 1));
        end while (c == 0);
    endtask

    // Stimulus: directed table first, then random triangles.
    initial begin
        t_triangle_row rows[$];
        t_side a;
        t_side b;
        t_side c;
        int kind;
        side_ch.valid  <= 1'b0;
        side_ch.side_a <= '0;
        side_ch.side_b <= '0;
        side_ch.side_c <= '0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero sides, degenerate and failing inequality give the flag and zero lengths.
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0000, 16'h0100, 16'h0100, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0100, 16'h0000, 16'h0100, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0100, 16'h0100, 16'h0000, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0200, 16'h0100, 16'h0100, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0100, 16'h0200, 16'h0100, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0100, 16'h0100, 16'h0200, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'hFFFF, 16'h0001, 16'h0001, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'h0001, 16'hFFFF, 16'h7FFF, 1'b1, {1'b1, 48'd0}});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, {1'b1, 48'd0}});
        // Valid extremes and near-degenerate shapes.
        rows.push_back('{16'h0001, 16'h0001, 16'h0001, 1'b0, '0});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, '0});
        rows.push_back('{16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, '0});
        rows.push_back('{16'hFFFE, 16'h7FFF, 16'h8000, 1'b0, '0});
        rows.push_back('{16'h0300, 16'h0400, 16'h0500, 1'b0, '0});
        rows.push_back('{16'hAAAA, 16'h5555, 16'h8000, 1'b0, '0});
        rows.push_back('{16'h5555, 16'hAAAA, 16'h8001, 1'b0, '0});
        rows.push_back('{16'h8000, 16'h8000, 16'hFFFF, 1'b0, '0});

        foreach (rows[i]) begin
            send_triangle(rows[i].a, rows[i].b, rows[i].c, 1'b0);
            if (rows[i].check_value && pending_bisectors[$] !== rows[i].value) begin
                $error("directed row %0d: predictor %h, table %h",
                       i, pending_bisectors[$], rows[i].value);
                fail_count++;
            end
        end

        // Hold off until the pipeline has drained.
        side_ch.valid <= 1'b0;
        wait (pending_bisectors.size() == 0);
        @(negedge i_clk);

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                random_triangle(a, b, c);
            end else begin
                a = t_side'($urandom());
                b = t_side'($urandom());
                c = t_side'($urandom());
                if (kind < 85) a = '0;
            end
            send_triangle(a, b, c, n % 200 >= 100);
            if (n == RANDOM_COUNT / 2) begin
                side_ch.valid <= 1'b0;
                wait (pending_bisectors.size() == 0);
                @(negedge i_clk);
            end
        end
        side_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stalls, compare each transaction with the oldest prediction.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        fail_count = 0;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_bisectors want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_bisectors.size() == 0) begin
                $error("result transaction with no prediction waiting");
                fail_count++;
            end else begin
                want = pending_bisectors.pop_front();
                if (res_ch.not_triangle !== want.not_triangle) begin
                    $error("not_triangle: expected %0d, got %0d",
                           want.not_triangle, res_ch.not_triangle);
                    fail_count++;
                end
                if (res_ch.bisector_a !== want.bisector_a) begin
                    $error("bisector_a: expected %h, got %h", want.bisector_a, res_ch.bisector_a);
                    fail_count++;
                end
                if (res_ch.bisector_b !== want.bisector_b) begin
                    $error("bisector_b: expected %h, got %h", want.bisector_b, res_ch.bisector_b);
                    fail_count++;
                end
                if (res_ch.bisector_c !== want.bisector_c) begin
                    $error("bisector_c: expected %h, got %h", want.bisector_c, res_ch.bisector_c);
                    fail_count++;
                end
            end
        end
    end

    // End of run and timeout.
    initial begin
        cycle_count = 0;
        while (!(stim_done && pending_bisectors.size() == 0) && cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
        end else begin
            repeat (LATENCY * 2) @(posedge i_clk);
            if (fail_count == 0 && pending_bisectors.size() == 0) begin
                $display("RESULT: OK");
            end else begin
                $display("RESULT: ERROR");
            end
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tad_pkg.sv
hw/rtl/tad_side_if.sv
hw/rtl/tad_result_if.sv
hw/rtl/tad_ctrl.sv
hw/rtl/tad_lane.sv
hw/rtl/triangle_angle_bisectors.sv
tb/tb_top.sv
